FILE: hdl/vector_table_nearest_neighbor_assert.svh
// Assertion macros used by the checker file.
`ifndef VECTOR_TABLE_NEAREST_NEIGHBOR_ASSERT_SVH
`define VECTOR_TABLE_NEAREST_NEIGHBOR_ASSERT_SVH

// Checked only while reset is released.
`define VTNN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define VTNN_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/vtnn_pkg.sv
`default_nettype none
package vtnn_pkg;
	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_INVALID   = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_NOT_FOUND = 2'd3;

	typedef enum logic [1:0] {
		OP_UPSERT = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam int COMP_W = 16;
	localparam int ID_W = 32;
	localparam int DIST_W = 19;
	localparam logic [DIST_W-1:0] DIST_MAX = 19'h7FFFF;

	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctl_t;
endpackage
`default_nettype wire

FILE: hdl/vtnn_mac.sv
`default_nettype none
module vtnn_mac import vtnn_pkg::*; #(
	parameter int ACC_W = 38
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mac_ctl_t                 ctl,
	input  wire logic signed [COMP_W-1:0] a,
	input  wire logic signed [COMP_W-1:0] b,
	output logic [ACC_W-1:0]              acc,
	output logic                          busy
);
	logic signed [COMP_W:0] d_s1;
	logic                   v_s1;
	logic [31:0]            sq_s2;
	logic                   v_s2;
	logic signed [2*COMP_W+1:0] prod;
	logic [ACC_W-1:0]       acc_q;

	assign prod = d_s1 * d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= {a[COMP_W-1], a} - {b[COMP_W-1], b};
		sq_s2 <= prod[31:0];
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(sq_s2);
		end
	end

	assign acc = acc_q;
	assign busy = v_s1 | v_s2;
endmodule
`default_nettype wire

FILE: hdl/vtnn_isqrt.sv
`default_nettype none
module vtnn_isqrt import vtnn_pkg::*; #(
	parameter int SQ_W = 38
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SQ_W-1:0]   value,
	output logic                   done,
	output logic [SQ_W/2-1:0]      root
);
	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W-1:0] trial;
	logic            run_q;
	logic            done_q;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			r_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (run_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[SQ_W/2-1:0];
endmodule
`default_nettype wire

FILE: hdl/vector_table_nearest_neighbor.sv
// A component that does not end a vector is taken without a stall and gives no result.
// A final upsert scans the stored ids for a match, then copies the vector into that or a new entry.
// A final query checks each entry's length and, on equal length, sums the squared differences
// in the one MAC; then the bit-serial square root of the best sum gives the distance.
// The input is stalled from a final beat or a clear until its result is handed on, one vector at a time.
// Reset empties the table and the incoming vector at once; no clearing pass is needed.
`default_nettype none
module vector_table_nearest_neighbor import vtnn_pkg::*; #(
	parameter int TABLE_ENTRIES = 256,
	parameter int MAX_LENGTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     item_valid,
	output logic                          item_stall,
	input  wire logic [1:0]               op,
	input  wire logic [ID_W-1:0]          node_id,
	input  wire logic signed [COMP_W-1:0] component,
	input  wire logic                     last,
	output logic                          result_valid,
	input  wire logic                     result_stall,
	output logic [1:0]                    status,
	output logic [ID_W-1:0]               match_id,
	output logic [DIST_W-1:0]             distance
);
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int K_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int LEN_W = $clog2(MAX_LENGTH + 1);
	localparam int ST_DEPTH = TABLE_ENTRIES * MAX_LENGTH;
	localparam int ST_W = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
	localparam int ACC_W = 32 + $clog2(MAX_LENGTH);
	localparam int SQ_W = ACC_W + (ACC_W % 2);
	localparam int R_W = SQ_W / 2;
	localparam int RX_W = R_W + DIST_W;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_U_RD   = 12'b000000000010,
		S_U_CMP  = 12'b000000000100,
		S_COPY   = 12'b000000001000,
		S_COMMIT = 12'b000000010000,
		S_Q_RD   = 12'b000000100000,
		S_Q_CMP  = 12'b000001000000,
		S_Q_DIST = 12'b000010000000,
		S_Q_WAIT = 12'b000100000000,
		S_Q_ID   = 12'b001000000000,
		S_SQRT   = 12'b010000000000,
		S_RESULT = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [COMP_W-1:0] store_mem [ST_DEPTH];
	logic [ID_W-1:0]   ids_mem [TABLE_ENTRIES];
	logic [LEN_W-1:0]  lens_mem [TABLE_ENTRIES];
	logic [COMP_W-1:0] buf_mem [MAX_LENGTH];

	logic [COMP_W-1:0] st_rd_q;
	logic [ID_W-1:0]   ids_rd_q;
	logic [LEN_W-1:0]  lens_rd_q;
	logic [COMP_W-1:0] buf_rd_q;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  i_q;
	logic [LEN_W-1:0]  k_q;
	logic [LEN_W-1:0]  inc_len_q;
	logic              ovf_q;
	logic [LEN_W-1:0]  len_q;
	logic [ID_W-1:0]   id_q;
	logic [IDX_W-1:0]  target_q;
	logic              new_q;
	logic              found_q;
	logic [ACC_W-1:0]  best_q;
	logic [IDX_W-1:0]  best_i_q;
	logic              cp_v_s1;
	logic [K_W-1:0]    cp_k_s1;
	logic              mv_s1;

	logic [1:0]        res_status_q;
	logic [ID_W-1:0]   res_match_q;
	logic [DIST_W-1:0] res_dist_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [ID_W-1:0]   out_match_q;
	logic [DIST_W-1:0] out_dist_q;

	logic              accept;
	logic              buf_we;
	logic              inc_room;
	logic [LEN_W-1:0]  len_new;
	logic              ovf_new;
	logic [K_W-1:0]    buf_raddr;
	logic [ST_W-1:0]   st_raddr;
	logic [ST_W-1:0]   st_waddr;
	logic              st_we;
	logic [IDX_W-1:0]  ids_raddr;
	logic [IDX_W-1:0]  lens_raddr;
	logic              meta_we;
	mac_ctl_t          mac_ctl;
	logic [ACC_W-1:0]  acc;
	logic              mac_busy;
	logic              sqrt_start;
	logic              sqrt_done;
	logic [R_W-1:0]    root;
	logic [RX_W-1:0]   root_x;
	logic [DIST_W-1:0] dist_sat;
	logic              out_free;

	assign item_stall = (state_q != S_IDLE);
	assign accept = item_valid && !item_stall;
	assign inc_room = (inc_len_q < LEN_W'(MAX_LENGTH));
	assign len_new = inc_room ? inc_len_q + LEN_W'(1) : inc_len_q;
	assign ovf_new = ovf_q || !inc_room;
	assign buf_we = accept && (op == OP_UPSERT || op == OP_QUERY) && inc_room;
	assign out_free = !out_valid_q || !result_stall;

	assign buf_raddr = k_q[K_W-1:0];
	assign st_raddr = ST_W'(i_q[IDX_W-1:0]) * ST_W'(MAX_LENGTH) + ST_W'(k_q[K_W-1:0]);
	assign st_waddr = ST_W'(target_q) * ST_W'(MAX_LENGTH) + ST_W'(cp_k_s1);
	assign st_we = (state_q == S_COPY) && cp_v_s1;
	assign ids_raddr = (state_q == S_U_RD) ? i_q[IDX_W-1:0] : best_i_q;
	assign lens_raddr = i_q[IDX_W-1:0];
	assign meta_we = (state_q == S_COMMIT);

	assign mac_ctl.clear = (state_q == S_Q_CMP);
	assign mac_ctl.valid = mv_s1;
	assign sqrt_start = (state_q == S_Q_ID);

	assign root_x = RX_W'(root);
	assign dist_sat = (root_x > RX_W'(DIST_MAX)) ? DIST_MAX : root_x[DIST_W-1:0];

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_mem[inc_len_q[K_W-1:0]] <= component;
		end
		buf_rd_q <= buf_mem[buf_raddr];
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_waddr] <= buf_rd_q;
		end
		st_rd_q <= store_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			ids_mem[target_q] <= id_q;
		end
		ids_rd_q <= ids_mem[ids_raddr];
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			lens_mem[target_q] <= len_q;
		end
		lens_rd_q <= lens_mem[lens_raddr];
	end

	vtnn_mac #(.ACC_W(ACC_W)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (buf_rd_q),
		.b      (st_rd_q),
		.acc    (acc),
		.busy   (mac_busy)
	);

	vtnn_isqrt #(.SQ_W(SQ_W)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (SQ_W'(best_q)),
		.done   (sqrt_done),
		.root   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			inc_len_q <= '0;
			ovf_q <= 1'b0;
			i_q <= '0;
			k_q <= '0;
			found_q <= 1'b0;
			new_q <= 1'b0;
			cp_v_s1 <= 1'b0;
			mv_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op)
							OP_CLEAR: begin
								count_q <= '0;
								inc_len_q <= '0;
								ovf_q <= 1'b0;
								res_status_q <= ST_OK;
								res_match_q <= '0;
								res_dist_q <= '0;
								state_q <= S_RESULT;
							end
							OP_UPSERT, OP_QUERY: begin
								if (last) begin
									inc_len_q <= '0;
									ovf_q <= 1'b0;
									len_q <= len_new;
									id_q <= node_id;
									i_q <= '0;
									found_q <= 1'b0;
									new_q <= 1'b0;
									res_match_q <= '0;
									res_dist_q <= '0;
									if (ovf_new || (op == OP_UPSERT && node_id == '0)) begin
										res_status_q <= ST_INVALID;
										state_q <= S_RESULT;
									end else if (op == OP_UPSERT) begin
										res_status_q <= ST_OK;
										state_q <= S_U_RD;
									end else begin
										res_status_q <= ST_OK;
										state_q <= S_Q_RD;
									end
								end else begin
									inc_len_q <= len_new;
									ovf_q <= ovf_new;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_U_RD: begin
					k_q <= '0;
					if (i_q == count_q) begin
						if (count_q == CNT_W'(TABLE_ENTRIES)) begin
							res_status_q <= ST_FULL;
							state_q <= S_RESULT;
						end else begin
							target_q <= count_q[IDX_W-1:0];
							new_q <= 1'b1;
							state_q <= S_COPY;
						end
					end else begin
						state_q <= S_U_CMP;
					end
				end
				S_U_CMP: begin
					if (ids_rd_q == id_q) begin
						target_q <= i_q[IDX_W-1:0];
						state_q <= S_COPY;
					end else begin
						i_q <= i_q + CNT_W'(1);
						state_q <= S_U_RD;
					end
				end
				S_COPY: begin
					if (k_q < len_q) begin
						cp_v_s1 <= 1'b1;
						cp_k_s1 <= k_q[K_W-1:0];
						k_q <= k_q + LEN_W'(1);
					end else begin
						cp_v_s1 <= 1'b0;
						if (!cp_v_s1) begin
							state_q <= S_COMMIT;
						end
					end
				end
				S_COMMIT: begin
					if (new_q) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= S_RESULT;
				end
				S_Q_RD: begin
					k_q <= '0;
					if (i_q == count_q) begin
						if (found_q) begin
							state_q <= S_Q_ID;
						end else begin
							res_status_q <= ST_NOT_FOUND;
							state_q <= S_RESULT;
						end
					end else begin
						state_q <= S_Q_CMP;
					end
				end
				S_Q_CMP: begin
					if (lens_rd_q != len_q) begin
						i_q <= i_q + CNT_W'(1);
						state_q <= S_Q_RD;
					end else begin
						state_q <= S_Q_DIST;
					end
				end
				S_Q_DIST: begin
					if (k_q < len_q) begin
						mv_s1 <= 1'b1;
						k_q <= k_q + LEN_W'(1);
					end else begin
						mv_s1 <= 1'b0;
						state_q <= S_Q_WAIT;
					end
				end
				S_Q_WAIT: begin
					if (!mv_s1 && !mac_busy) begin
						if (!found_q || acc < best_q) begin
							best_q <= acc;
							best_i_q <= i_q[IDX_W-1:0];
							found_q <= 1'b1;
						end
						i_q <= i_q + CNT_W'(1);
						state_q <= S_Q_RD;
					end
				end
				S_Q_ID: begin
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sqrt_done) begin
						res_match_q <= ids_rd_q;
						res_dist_q <= dist_sat;
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_match_q <= res_match_q;
						out_dist_q <= res_dist_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign status = out_status_q;
	assign match_id = out_match_q;
	assign distance = out_dist_q;
endmodule
`default_nettype wire

FILE: hdl/vtnn_checker.sv
`default_nettype none
`include "vector_table_nearest_neighbor_assert.svh"
module vtnn_checker import vtnn_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_stall,
	input wire logic [1:0]        op,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire logic [1:0]        status,
	input wire logic [ID_W-1:0]   match_id,
	input wire logic [DIST_W-1:0] distance
);
	`VTNN_ASSERT(a_hold, result_valid && result_stall |=> result_valid && $stable(status) && $stable(match_id) && $stable(distance), "stalled result changed")
	`VTNN_ASSERT(a_fail_zero, result_valid && status != ST_OK |-> match_id == '0 && distance == '0, "failed result carries data")
	`VTNN_ASSERT(a_clear_busy, item_valid && !item_stall && op == OP_CLEAR |=> item_stall, "clear did not hold off input")
	`VTNN_ASSERT_ALWAYS(a_reset, !arst_n |=> !result_valid, "result during reset")
endmodule

bind vector_table_nearest_neighbor vtnn_checker u_vtnn_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.op           (op),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.status       (status),
	.match_id     (match_id),
	.distance     (distance)
);
`default_nettype wire
